@@ src/tthb_pkg.sv @@
// ----------------------------------------------------------------------------
// tthb_pkg
// Shared types and constants for the tick timer bank with heartbeat.
// ----------------------------------------------------------------------------
package tthb_pkg;

  localparam int ReqTypeW   = 2;
  localparam int TimerIdW   = 3;
  localparam int IntervalW  = 32;
  localparam int MaskW      = 8;
  localparam int HbW        = 24;
  localparam int ShiftW     = 5;
  localparam int ApbDataW   = 32;
  localparam int ApbAddrW   = 3;

  localparam int TimerCountDef = 8;
  localparam int CountWidthDef = 32;

  localparam logic [HbW-1:0]    HbReloadRst = HbW'(1000);
  localparam logic [ShiftW-1:0] ShiftRst    = '0;

  typedef enum logic [ReqTypeW-1:0] {
    REQ_FAST  = 2'd0,
    REQ_BASE  = 2'd1,
    REQ_CHECK = 2'd2,
    REQ_SET   = 2'd3
  } req_type_e;

  typedef enum logic [0:0] {
    REG_HB_RELOAD = 1'b0,
    REG_SHIFT     = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic                fast_tick_seen;
    logic                base_tick_seen;
    logic                heartbeat_pulse;
    logic [MaskW-1:0]    running_mask;
  } rsp_t;

  typedef struct packed {
    logic                step;
    logic                load;
    logic [TimerIdW-1:0] id;
  } bank_ctrl_t;

endpackage

@@ src/tthb_if.sv @@
// ----------------------------------------------------------------------------
// tthb_if
// Valid/ready channels for requests and results of the timer bank.
// ----------------------------------------------------------------------------
interface tthb_req_if;
  logic                               valid;
  logic                               ready;
  logic [tthb_pkg::ReqTypeW-1:0]      req_type;
  logic [tthb_pkg::TimerIdW-1:0]      timer_id;
  logic [tthb_pkg::IntervalW-1:0]     interval;

  modport source (output valid, req_type, timer_id, interval, input ready);
  modport sink (input valid, req_type, timer_id, interval, output ready);
endinterface

interface tthb_rsp_if;
  logic                               valid;
  logic                               ready;
  logic                               fast_tick_seen;
  logic                               base_tick_seen;
  logic                               heartbeat_pulse;
  logic [tthb_pkg::MaskW-1:0]         running_mask;

  modport source (output valid, fast_tick_seen, base_tick_seen, heartbeat_pulse,
                  running_mask, input ready);
  modport sink (input valid, fast_tick_seen, base_tick_seen, heartbeat_pulse,
                running_mask, output ready);
endinterface

@@ src/tthb_bank.sv @@
// ----------------------------------------------------------------------------
// tthb_bank
// Bank of one-shot down counters with one running bit per timer.
// ----------------------------------------------------------------------------
module tthb_bank #(
  parameter int TimerCount = tthb_pkg::TimerCountDef,
  parameter int CountWidth = tthb_pkg::CountWidthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  tthb_pkg::bank_ctrl_t     ctrl_i,
  input  logic [CountWidth-1:0]    load_count_i,
  output logic [TimerCount-1:0]    run_next_o
);

  logic [TimerCount-1:0] run_q;
  logic [TimerCount-1:0] run_d;
  logic [CountWidth-1:0] cnt_q [TimerCount];
  logic [CountWidth-1:0] cnt_d [TimerCount];
  logic [TimerCount-1:0] hit;

  for (genvar i = 0; i < TimerCount; i++) begin : g_timer
    if (i < (1 << tthb_pkg::TimerIdW)) begin : g_addr
      assign hit[i] = ctrl_i.load && (ctrl_i.id == tthb_pkg::TimerIdW'(i));
    end else begin : g_noaddr
      assign hit[i] = 1'b0;
    end

    always_comb begin
      run_d[i] = run_q[i];
      cnt_d[i] = cnt_q[i];
      if (hit[i]) begin
        run_d[i] = 1'b1;
        cnt_d[i] = load_count_i;
      end else if (ctrl_i.step && run_q[i]) begin
        if (cnt_q[i] <= CountWidth'(1)) begin
          run_d[i] = 1'b0;
          cnt_d[i] = '0;
        end else begin
          cnt_d[i] = cnt_q[i] - CountWidth'(1);
        end
      end
    end

    always_ff @(posedge clk_i) begin
      cnt_q[i] <= cnt_d[i];
    end

    ExpireStops: assert property (@(posedge clk_i) disable iff (!rst_ni)
      ctrl_i.step && run_q[i] && (cnt_q[i] <= CountWidth'(1)) && !hit[i] |=> !run_q[i])
      else $error("timer did not stop on expiry");
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
    end else begin
      run_q <= run_d;
    end
  end

  assign run_next_o = run_d;

  LoadStarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.load && (32'(ctrl_i.id) < TimerCount) |=> run_q != '0)
    else $error("loaded timer is not running");

  NoStepWithLoad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.step && ctrl_i.load))
    else $error("step and load in the same cycle");

endmodule

@@ src/tick_timer_bank_with_heartbeat_top.sv @@
// ----------------------------------------------------------------------------
// tick_timer_bank_with_heartbeat_top
// One-shot timer bank stepped by checked base ticks, with heartbeat prescaler.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake      Payload
// req_i     in         valid/ready    req_type, timer_id, interval
// rsp_o     out        valid/ready    fast_tick_seen, base_tick_seen,
//                                     heartbeat_pulse, running_mask
// APB       in         psel/penable   heartbeat_reload, interval_shift
//
// Each transaction yields one registered result in the two-entry output buffer.
// A new transaction is taken every cycle unless the buffer's skid entry is full.
// Reset clears all flags and the heartbeat prescaler loads 1000.
// When the result side stalls, one more transaction is held in the skid entry.
// ----------------------------------------------------------------------------
module tick_timer_bank_with_heartbeat_top #(
  parameter int TimerCount = tthb_pkg::TimerCountDef,
  parameter int CountWidth = tthb_pkg::CountWidthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  tthb_req_if.sink                          req_i,
  tthb_rsp_if.source                        rsp_o,
  input  logic                              psel_i,
  input  logic                              penable_i,
  input  logic                              pwrite_i,
  input  logic [tthb_pkg::ApbAddrW-1:0]     paddr_i,
  input  logic [tthb_pkg::ApbDataW-1:0]     pwdata_i,
  output logic [tthb_pkg::ApbDataW-1:0]     prdata_o,
  output logic                              pready_o
);

  logic [tthb_pkg::HbW-1:0]    hb_reload_q;
  logic [tthb_pkg::ShiftW-1:0] shift_q;
  tthb_pkg::reg_idx_e          reg_idx;
  logic                        cfg_wr;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i;
  assign reg_idx  = tthb_pkg::reg_idx_e'(paddr_i[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hb_reload_q <= tthb_pkg::HbReloadRst;
      shift_q     <= tthb_pkg::ShiftRst;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        tthb_pkg::REG_HB_RELOAD: hb_reload_q <= pwdata_i[tthb_pkg::HbW-1:0];
        tthb_pkg::REG_SHIFT:     shift_q     <= pwdata_i[tthb_pkg::ShiftW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      tthb_pkg::REG_HB_RELOAD: prdata_o = tthb_pkg::ApbDataW'(hb_reload_q);
      tthb_pkg::REG_SHIFT:     prdata_o = tthb_pkg::ApbDataW'(shift_q);
      default:                 prdata_o = '0;
    endcase
  end

  logic                        accept;
  logic                        pop;
  logic                        is_check;
  logic                        fast_pend_q, fast_pend_d;
  logic                        base_pend_q, base_pend_d;
  logic [tthb_pkg::HbW-1:0]    hb_left_q, hb_left_d;
  logic                        pulse;
  tthb_pkg::req_type_e         req_type;
  tthb_pkg::bank_ctrl_t        bank_ctrl;
  logic [tthb_pkg::IntervalW-1:0] shifted;
  logic [TimerCount-1:0]       run_next;
  logic [tthb_pkg::MaskW-1:0]  mask;
  tthb_pkg::rsp_t              rsp_new;

  assign req_type = tthb_pkg::req_type_e'(req_i.req_type);
  assign is_check = accept && (req_type == tthb_pkg::REQ_CHECK);

  always_comb begin
    fast_pend_d = fast_pend_q;
    base_pend_d = base_pend_q;
    hb_left_d   = hb_left_q;
    pulse       = 1'b0;
    if (accept) begin
      case (req_type)
        tthb_pkg::REQ_FAST: fast_pend_d = 1'b1;
        tthb_pkg::REQ_BASE: base_pend_d = 1'b1;
        tthb_pkg::REQ_CHECK: begin
          fast_pend_d = 1'b0;
          base_pend_d = 1'b0;
          if (base_pend_q) begin
            if (hb_left_q <= tthb_pkg::HbW'(1)) begin
              pulse     = 1'b1;
              hb_left_d = (hb_reload_q == '0) ? tthb_pkg::HbW'(1) : hb_reload_q;
            end else begin
              hb_left_d = hb_left_q - tthb_pkg::HbW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_pend_q <= 1'b0;
      base_pend_q <= 1'b0;
      hb_left_q   <= tthb_pkg::HbReloadRst;
    end else begin
      fast_pend_q <= fast_pend_d;
      base_pend_q <= base_pend_d;
      hb_left_q   <= hb_left_d;
    end
  end

  assign shifted        = req_i.interval >> shift_q;
  assign bank_ctrl.step = is_check && base_pend_q;
  assign bank_ctrl.load = accept && (req_type == tthb_pkg::REQ_SET);
  assign bank_ctrl.id   = req_i.timer_id;

  tthb_bank #(
    .TimerCount (TimerCount),
    .CountWidth (CountWidth)
  ) u_bank (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (bank_ctrl),
    .load_count_i (shifted[CountWidth-1:0]),
    .run_next_o   (run_next)
  );

  for (genvar b = 0; b < tthb_pkg::MaskW; b++) begin : g_mask
    if (b < TimerCount) begin : g_on
      assign mask[b] = run_next[b];
    end else begin : g_off
      assign mask[b] = 1'b0;
    end
  end

  assign rsp_new.fast_tick_seen  = is_check && fast_pend_q;
  assign rsp_new.base_tick_seen  = is_check && base_pend_q;
  assign rsp_new.heartbeat_pulse = pulse;
  assign rsp_new.running_mask    = mask;

  logic           out_valid_q;
  logic           skid_valid_q;
  tthb_pkg::rsp_t out_data_q;
  tthb_pkg::rsp_t skid_data_q;

  assign req_i.ready = !skid_valid_q;
  assign accept      = req_i.valid && !skid_valid_q;
  assign pop         = out_valid_q && rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_data_q <= skid_data_q;
      end
    end else if (accept) begin
      if (!out_valid_q || pop) begin
        out_data_q <= rsp_new;
      end else begin
        skid_data_q <= rsp_new;
      end
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.fast_tick_seen  = out_data_q.fast_tick_seen;
  assign rsp_o.base_tick_seen  = out_data_q.base_tick_seen;
  assign rsp_o.heartbeat_pulse = out_data_q.heartbeat_pulse;
  assign rsp_o.running_mask    = out_data_q.running_mask;

  SkidNeedsOut: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid while output register empty");

  HbNeverZero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hb_left_q != '0)
    else $error("heartbeat prescaler reached zero");

  CheckClears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_check |=> !fast_pend_q && !base_pend_q)
    else $error("pending flags survive a check");

  PulseOnlyOnTick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pulse |-> bank_ctrl.step)
    else $error("heartbeat pulse without a checked base tick");

endmodule

@@ tb/tick_timer_bank_with_heartbeat_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tick_timer_bank_with_heartbeat_top_tb
// Self-checking testbench for the tick timer bank with heartbeat.
// A scoreboard class keeps its own copy of the pending flags, the heartbeat
// prescaler and the timer counts. It predicts one result per accepted request
// and compares every returned result with the oldest prediction. Directed
// requests are followed by random traffic under several register settings,
// with random idling on both channels, a stretch without any idling and a
// long result-side stall.
// ----------------------------------------------------------------------------
module tick_timer_bank_with_heartbeat_top_tb;

  localparam int CycleLimit = 100000;
  localparam int HoldCycles = 80;

  class timer_bank_tracker;
    logic                             fast_pend;
    logic                             base_pend;
    logic [tthb_pkg::HbW-1:0]         hb_left;
    logic [tthb_pkg::MaskW-1:0]       running;
    logic [31:0]                      remaining [tthb_pkg::TimerCountDef];
    logic [tthb_pkg::HbW-1:0]         reload;
    logic [tthb_pkg::ShiftW-1:0]      shift;
    tthb_pkg::rsp_t                   due_rsps [$];
    int                               mismatches;
    int                               requests;
    int                               pulses;
    int                               expiries;

    function new();
      fast_pend  = 1'b0;
      base_pend  = 1'b0;
      hb_left    = tthb_pkg::HbReloadRst;
      running    = '0;
      reload     = tthb_pkg::HbReloadRst;
      shift      = tthb_pkg::ShiftRst;
      mismatches = 0;
      requests   = 0;
      pulses     = 0;
      expiries   = 0;
      foreach (remaining[i]) remaining[i] = '0;
    endfunction

    function void write_reg(tthb_pkg::reg_idx_e idx,
                            logic [tthb_pkg::ApbDataW-1:0] value);
      case (idx)
        tthb_pkg::REG_HB_RELOAD: reload = value[tthb_pkg::HbW-1:0];
        tthb_pkg::REG_SHIFT:     shift  = value[tthb_pkg::ShiftW-1:0];
      endcase
    endfunction

    function void note_request(tthb_pkg::req_type_e kind,
                               logic [tthb_pkg::TimerIdW-1:0] id,
                               logic [tthb_pkg::IntervalW-1:0] ivl);
      tthb_pkg::rsp_t want;
      want = '0;
      requests++;
      case (kind)
        tthb_pkg::REQ_FAST: fast_pend = 1'b1;
        tthb_pkg::REQ_BASE: base_pend = 1'b1;
        tthb_pkg::REQ_CHECK: begin
          if (fast_pend) begin
            fast_pend = 1'b0;
            want.fast_tick_seen = 1'b1;
          end
          if (base_pend) begin
            base_pend = 1'b0;
            want.base_tick_seen = 1'b1;
            if (hb_left <= 1) begin
              hb_left = (reload == '0) ? tthb_pkg::HbW'(1) : reload;
              want.heartbeat_pulse = 1'b1;
              pulses++;
            end else begin
              hb_left = hb_left - tthb_pkg::HbW'(1);
            end
            for (int i = 0; i < tthb_pkg::TimerCountDef; i++) begin
              if (running[i]) begin
                if (remaining[i] <= 1) begin
                  remaining[i] = '0;
                  running[i] = 1'b0;
                  expiries++;
                end else begin
                  remaining[i] = remaining[i] - 32'd1;
                end
              end
            end
          end
        end
        tthb_pkg::REQ_SET: begin
          remaining[id] = ivl >> shift;
          running[id] = 1'b1;
        end
      endcase
      want.running_mask = running;
      due_rsps.push_back(want);
    endfunction

    function void check_result(tthb_pkg::rsp_t got);
      tthb_pkg::rsp_t want;
      if (due_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected result: fast=%0b base=%0b pulse=%0b mask=%02h",
                   got.fast_tick_seen, got.base_tick_seen, got.heartbeat_pulse,
                   got.running_mask);
        end
      end else begin
        want = due_rsps.pop_front();
        if (got.fast_tick_seen !== want.fast_tick_seen ||
            got.base_tick_seen !== want.base_tick_seen ||
            got.heartbeat_pulse !== want.heartbeat_pulse ||
            got.running_mask !== want.running_mask) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: expected fast=%0b base=%0b pulse=%0b mask=%02h,",
                     want.fast_tick_seen, want.base_tick_seen,
                     want.heartbeat_pulse, want.running_mask);
            $display("          actual   fast=%0b base=%0b pulse=%0b mask=%02h",
                     got.fast_tick_seen, got.base_tick_seen,
                     got.heartbeat_pulse, got.running_mask);
          end
        end
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          psel_i;
  logic                          penable_i;
  logic                          pwrite_i;
  logic [tthb_pkg::ApbAddrW-1:0] paddr_i;
  logic [tthb_pkg::ApbDataW-1:0] pwdata_i;
  logic [tthb_pkg::ApbDataW-1:0] prdata_o;
  logic                          pready_o;

  tthb_req_if req_ch ();
  tthb_rsp_if rsp_ch ();

  tick_timer_bank_with_heartbeat_top dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_ch),
    .rsp_o     (rsp_ch),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o)
  );

  timer_bank_tracker tracker;
  bit                quiet;
  int                hold_reqs;
  int                cycles;
  int                settings;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    tthb_pkg::rsp_t got;
    int             hold_left;
    int             hold_seen;
    hold_left = 0;
    hold_seen = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
        got.fast_tick_seen  = rsp_ch.fast_tick_seen;
        got.base_tick_seen  = rsp_ch.base_tick_seen;
        got.heartbeat_pulse = rsp_ch.heartbeat_pulse;
        got.running_mask    = rsp_ch.running_mask;
        tracker.check_result(got);
      end
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= quiet || ($urandom_range(0, 99) >= 10);
      end
    end
  end

  task automatic send_request(tthb_pkg::req_type_e kind,
                              logic [tthb_pkg::TimerIdW-1:0] id,
                              logic [tthb_pkg::IntervalW-1:0] ivl);
    if (!quiet && $urandom_range(0, 99) < 10) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.timer_id <= id;
    req_ch.interval <= ivl;
    do @(posedge clk_i); while (!req_ch.ready);
    tracker.note_request(kind, id, ivl);
  endtask

  task automatic apb_write(tthb_pkg::reg_idx_e idx,
                           logic [tthb_pkg::ApbDataW-1:0] value);
    @(posedge clk_i);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= tthb_pkg::ApbAddrW'({idx, 2'b00});
    pwdata_i  <= value;
    @(posedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
    tracker.write_reg(idx, value);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (tracker.due_rsps.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic configure(logic [tthb_pkg::ApbDataW-1:0] reload,
                           logic [tthb_pkg::ApbDataW-1:0] shift);
    wait_drained();
    apb_write(tthb_pkg::REG_HB_RELOAD, reload);
    apb_write(tthb_pkg::REG_SHIFT, shift);
    settings++;
  endtask

  function automatic logic [tthb_pkg::IntervalW-1:0] pick_interval();
    logic [63:0] ivl;
    if ($urandom_range(0, 19) == 0) begin
      return $urandom;
    end
    ivl = (64'($urandom_range(0, 12)) << tracker.shift) |
          (64'($urandom) & ((64'd1 << tracker.shift) - 64'd1));
    return ivl[tthb_pkg::IntervalW-1:0];
  endfunction

  task automatic send_random(int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        send_request(tthb_pkg::REQ_FAST, tthb_pkg::TimerIdW'($urandom), $urandom);
      end else if (pick < 45) begin
        send_request(tthb_pkg::REQ_BASE, tthb_pkg::TimerIdW'($urandom), $urandom);
      end else if (pick < 85) begin
        send_request(tthb_pkg::REQ_CHECK, tthb_pkg::TimerIdW'($urandom), $urandom);
      end else begin
        send_request(tthb_pkg::REQ_SET, tthb_pkg::TimerIdW'($urandom),
                     pick_interval());
      end
    end
  endtask

  initial begin
    tracker   = new();
    quiet     = 1'b0;
    settings  = 1;
    rst_ni          <= 1'b0;
    psel_i          <= 1'b0;
    penable_i       <= 1'b0;
    pwrite_i        <= 1'b0;
    paddr_i         <= '0;
    pwdata_i        <= '0;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= tthb_pkg::REQ_FAST;
    req_ch.timer_id <= '0;
    req_ch.interval <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    send_request(tthb_pkg::REQ_CHECK, 3'd0, 32'h0);
    send_request(tthb_pkg::REQ_FAST, 3'd7, 32'hFFFF_FFFF);
    send_request(tthb_pkg::REQ_CHECK, 3'd0, 32'h0);
    send_request(tthb_pkg::REQ_BASE, 3'd0, 32'h0);
    send_request(tthb_pkg::REQ_CHECK, 3'd0, 32'h0);
    send_request(tthb_pkg::REQ_FAST, 3'd0, 32'h0);
    send_request(tthb_pkg::REQ_BASE, 3'd0, 32'h0);
    send_request(tthb_pkg::REQ_CHECK, 3'd0, 32'h0);
    send_request(tthb_pkg::REQ_SET, 3'd0, 32'h0);
    send_request(tthb_pkg::REQ_SET, 3'd7, 32'hFFFF_FFFF);
    send_request(tthb_pkg::REQ_SET, 3'd1, 32'd2);
    send_request(tthb_pkg::REQ_BASE, 3'd0, 32'h0);
    send_request(tthb_pkg::REQ_CHECK, 3'd0, 32'h0);
    send_request(tthb_pkg::REQ_BASE, 3'd0, 32'h0);
    send_request(tthb_pkg::REQ_CHECK, 3'd0, 32'h0);
    send_request(tthb_pkg::REQ_SET, 3'd1, 32'd5);
    send_request(tthb_pkg::REQ_SET, 3'd1, 32'd1);
    send_request(tthb_pkg::REQ_BASE, 3'd0, 32'h0);
    send_request(tthb_pkg::REQ_BASE, 3'd0, 32'h0);
    send_request(tthb_pkg::REQ_CHECK, 3'd0, 32'h0);
    send_request(tthb_pkg::REQ_FAST, 3'd0, 32'h0);
    send_request(tthb_pkg::REQ_FAST, 3'd0, 32'h0);
    send_request(tthb_pkg::REQ_CHECK, 3'd0, 32'h0);
    send_request(tthb_pkg::REQ_CHECK, 3'd0, 32'h0);

    configure(32'd3, 32'd0);
    quiet = 1'b1;
    send_random(100);
    quiet = 1'b0;
    send_random(100);

    configure(32'd1, 32'd31);
    hold_reqs++;
    send_random(120);

    configure(32'd0, 32'($urandom_range(1, 30)));
    send_random(60);
    wait_drained();
    send_random(60);

    configure(32'h00FF_FFFF, 32'd2);
    send_random(120);

    configure(32'($urandom_range(2, 9)), 32'($urandom_range(0, 4)));
    send_random(150);

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("Run covered %0d requests under %0d register settings.",
             tracker.requests, settings);
    $display("Seen %0d heartbeat pulses and %0d timer expiries, %0d mismatches.",
             tracker.pulses, tracker.expiries, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.due_rsps.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/tthb_pkg.sv
src/tthb_if.sv
src/tthb_bank.sv
src/tick_timer_bank_with_heartbeat_top.sv
tb/tick_timer_bank_with_heartbeat_top_tb.sv
